/* rtl/mplt_pkg.sv */
package mplt_pkg;

   localparam int SUM_W = 26;
   localparam int SQ_W = 48;
   localparam int CNT_W = 7;
   localparam int K_W = 4;
   localparam int MASK_W = 2;

   localparam logic [K_W-1:0] K_RESET = 4'd4;

   localparam int LANE_Q3 = 0;
   localparam int LANE_Q4 = 1;

   localparam int K_OFFSET_Q3 = 2;
   localparam int K_OFFSET_Q4 = 3;

endpackage

/* rtl/mplt_square.sv */
module mplt_square #(
   parameter int W = 51
) (
   input  logic           clock,
   input  logic [W-1:0]   operand,
   output logic [2*W-1:0] square
);

   localparam int LW = (W + 1) / 2;
   localparam int HW = W - LW;

   logic [LW-1:0]      lo;
   logic [HW-1:0]      hi;
   logic [2*HW-1:0]    hh_in, hh_ff;
   logic [HW+LW-1:0]   hl_in, hl_ff;
   logic [2*LW-1:0]    ll_in, ll_ff;
   logic [2*W-1:0]     square_in, square_ff;

   always_comb begin
      lo = operand[LW-1:0];
      hi = operand[W-1:LW];
      hh_in = (2*HW)'(hi) * (2*HW)'(hi);
      hl_in = (HW+LW)'(hi) * (HW+LW)'(lo);
      ll_in = (2*LW)'(lo) * (2*LW)'(lo);
      square_in = ((2*W)'(hh_ff) << (2*LW)) + ((2*W)'(hl_ff) << (LW + 1))
                  + (2*W)'(ll_ff);
   end

   always_ff @(posedge clock) begin
      hh_ff <= hh_in;
      hl_ff <= hl_in;
      ll_ff <= ll_in;
      square_ff <= square_in;
   end

   assign square = square_ff;

endmodule

/* rtl/moment_pair_lane_test_unit.sv */
// Moment pair lane test unit.
// The requester presents two points, the moments of a site group and a lane
// mask on the req_ ports and raises start; a transfer happens at every rising
// edge with start high and busy low. busy is always low, so a new transfer
// may come in every cycle.
// For each transfer, rsp_valid is high for exactly one cycle with the two
// lane flags on rsp_lane_q3_pass and rsp_lane_q4_pass; a flag is low when
// its lane was not requested. Results leave in transfer order, one per
// cycle at most. The pipeline has nine register stages: products of
// coordinates, moment products, the h and w sums, the cross and order
// products, the cross components and magnitudes, two stages for each wide
// square split into half-width partial products, the sum of squares, and the
// final compare.
// The receiver cannot stall and the pipeline never holds. csr_write_enable
// loads order_k from csr_write_data; it should only change while no transfer
// is in flight.
// Synchronous reset clears all valid bits and sets order_k to 4; transfers
// in flight at reset are dropped.
module moment_pair_lane_test_unit #(
   parameter int COORD_BITS = 20,
   parameter int GROUP_MAX = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [COORD_BITS-1:0]               req_point_a_x,
   input  logic [COORD_BITS-1:0]               req_point_a_y,
   input  logic [COORD_BITS-1:0]               req_point_a_z,
   input  logic [COORD_BITS-1:0]               req_point_b_x,
   input  logic [COORD_BITS-1:0]               req_point_b_y,
   input  logic [COORD_BITS-1:0]               req_point_b_z,
   input  logic [mplt_pkg::CNT_W-1:0]          req_group_count,
   input  logic [mplt_pkg::SQ_W-1:0]           req_group_sq_sum,
   input  logic [mplt_pkg::SUM_W-1:0]          req_group_sum_x,
   input  logic [mplt_pkg::SUM_W-1:0]          req_group_sum_y,
   input  logic [mplt_pkg::SUM_W-1:0]          req_group_sum_z,
   input  logic [mplt_pkg::MASK_W-1:0]         req_lane_mask,
   output logic                                rsp_valid,
   output logic                                rsp_lane_q3_pass,
   output logic                                rsp_lane_q4_pass,
   input  logic                                csr_write_enable,
   input  logic [mplt_pkg::K_W-1:0]            csr_write_data
);

   localparam int CB = COORD_BITS;
   localparam int SUM_W = mplt_pkg::SUM_W;
   localparam int SQ_W = mplt_pkg::SQ_W;
   localparam int CNT_W = mplt_pkg::CNT_W;
   localparam int K_W = mplt_pkg::K_W;
   localparam int MASK_W = mplt_pkg::MASK_W;

   localparam int DW = CB + 1;
   localparam int SW = CB + 1;
   localparam int ABP_W = 2 * CB;
   localparam int ABS_W = 2 * CB + 2;
   localparam int NAB_W = ABS_W + CNT_W;
   localparam int SZP_W = SW + SUM_W;
   localparam int SZS_W = SZP_W + 2;
   localparam int NS_W = CNT_W + SW;
   localparam int DSP_W = 2 * CB;
   localparam int DSQ_W = 2 * CB + 2;
   localparam int WW = ((SUM_W + 1 > NS_W) ? SUM_W + 1 : NS_W) + 1;
   localparam int IW0 = (NAB_W > SZS_W) ? NAB_W : SZS_W;
   localparam int IW = ((IW0 > SQ_W) ? IW0 : SQ_W) + 2;
   localparam int HW = IW + 2;
   localparam int KS_W = K_W + 1;
   localparam int KD_W = KS_W + DSQ_W + 1;
   localparam int AW = ((HW + 2 > KD_W + 2) ? HW + 2 : KD_W + 2) + 1;
   localparam int AM_W = AW - 1;
   localparam int CPW = DW + WW;
   localparam int CW = CPW + 1;
   localparam int X_W = 2 * CW + 2;
   localparam int X12_W = X_W + 4;
   localparam int ASQ_W = 2 * AM_W;
   localparam int CMP_W = (X12_W > ASQ_W) ? X12_W : ASQ_W;
   localparam int NST = 8;
   localparam int LAT = NST + 1;

   localparam logic signed [KS_W-1:0] KOFF3 = KS_W'(mplt_pkg::K_OFFSET_Q3);
   localparam logic signed [KS_W-1:0] KOFF4 = KS_W'(mplt_pkg::K_OFFSET_Q4);

   logic [K_W-1:0] order_k_in, order_k_ff;
   logic           accept;
   logic [NST-1:0] valid_in, valid_ff;

   logic [CB-1:0]             pa [3];
   logic [CB-1:0]             pb [3];
   logic [SUM_W-1:0]          zin [3];

   logic signed [DW-1:0]      d1_in [3], d1_ff [3];
   logic [SW-1:0]             s1_in [3], s1_ff [3];
   logic [ABP_W-1:0]          abp1_in [3], abp1_ff [3];
   logic [CNT_W-1:0]          n1_in, n1_ff;
   logic [SUM_W-1:0]          z1_ff [3];
   logic [SQ_W-1:0]           q1_ff;
   logic [MASK_W-1:0]         m1_ff;

   logic [ABS_W-1:0]          abs2;
   logic [NAB_W-1:0]          nab2_in, nab2_ff;
   logic [SZP_W-1:0]          szp2_in [3], szp2_ff [3];
   logic [NS_W-1:0]           ns2_in [3], ns2_ff [3];
   logic [DSP_W-1:0]          dsp2_in [3], dsp2_ff [3];
   logic signed [2*DW-1:0]    dprod2 [3];
   logic signed [DW-1:0]      d2_ff [3];
   logic [SUM_W-1:0]          z2_ff [3];
   logic [SQ_W-1:0]           q2_ff;
   logic [MASK_W-1:0]         m2_ff;

   logic [SZS_W-1:0]          szs3;
   logic signed [IW-1:0]      inner3;
   logic signed [HW-1:0]      h3_in, h3_ff;
   logic signed [WW-1:0]      w3_in [3], w3_ff [3];
   logic [DSQ_W-1:0]          dsq3_in, dsq3_ff;
   logic signed [DW-1:0]      d3_ff [3];
   logic [MASK_W-1:0]         m3_ff;

   logic signed [KS_W-1:0]    ks3, ks4;
   logic signed [CPW-1:0]     cp4_in [6], cp4_ff [6];
   logic signed [KD_W-1:0]    kd3_in, kd3_ff, kd4_in, kd4_ff;
   logic signed [HW-1:0]      h4_ff;
   logic [MASK_W-1:0]         m4_ff;

   logic signed [CW-1:0]      c5 [3];
   logic signed [AW-1:0]      a3v, a4v;
   logic [CW-1:0]             cmag5_in [3], cmag5_ff [3];
   logic [AM_W-1:0]           amag5_in [2], amag5_ff [2];
   logic [1:0]                apos5_in, apos5_ff, apos6_ff, apos7_ff, apos8_ff;
   logic [MASK_W-1:0]         m5_ff, m6_ff, m7_ff, m8_ff;

   logic [2*CW-1:0]           csq7 [3];
   logic [ASQ_W-1:0]          asq7 [2];
   logic [X_W-1:0]            x7;
   logic [X12_W-1:0]          x8_in, x8_ff, x12_in, x12_ff;
   logic [ASQ_W-1:0]          asq8_ff [2];

   logic                      rsp_valid_in, rsp_valid_ff;
   logic                      q3_in, q3_ff, q4_in, q4_ff;

   assign busy = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      order_k_in = csr_write_enable ? csr_write_data : order_k_ff;
      valid_in = {valid_ff[NST-2:0], accept};
      rsp_valid_in = valid_ff[NST-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_k_ff <= mplt_pkg::K_RESET;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         q3_ff <= 1'b0;
         q4_ff <= 1'b0;
      end else begin
         order_k_ff <= order_k_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         q3_ff <= q3_in;
         q4_ff <= q4_in;
      end
   end

   // Stage 1: differences, sums, coordinate products, count saturation.
   always_comb begin
      pa[0] = req_point_a_x;
      pa[1] = req_point_a_y;
      pa[2] = req_point_a_z;
      pb[0] = req_point_b_x;
      pb[1] = req_point_b_y;
      pb[2] = req_point_b_z;
      zin[0] = req_group_sum_x;
      zin[1] = req_group_sum_y;
      zin[2] = req_group_sum_z;
      for (int i = 0; i < 3; i++) begin
         d1_in[i] = DW'(signed'({1'b0, pb[i]})) - DW'(signed'({1'b0, pa[i]}));
         s1_in[i] = SW'(pa[i]) + SW'(pb[i]);
         abp1_in[i] = ABP_W'(pa[i]) * ABP_W'(pb[i]);
      end
      n1_in = (req_group_count > CNT_W'(GROUP_MAX)) ? CNT_W'(GROUP_MAX) : req_group_count;
   end

   // Stage 2: moment products and squared differences.
   always_comb begin
      abs2 = ABS_W'(abp1_ff[0]) + ABS_W'(abp1_ff[1]) + ABS_W'(abp1_ff[2]);
      nab2_in = NAB_W'(n1_ff) * NAB_W'(abs2);
      for (int i = 0; i < 3; i++) begin
         szp2_in[i] = SZP_W'(s1_ff[i]) * SZP_W'(z1_ff[i]);
         ns2_in[i] = NS_W'(n1_ff) * NS_W'(s1_ff[i]);
         dprod2[i] = (2*DW)'(d1_ff[i]) * (2*DW)'(d1_ff[i]);
         dsp2_in[i] = dprod2[i][DSP_W-1:0];
      end
   end

   // Stage 3: h, w and the squared distance.
   always_comb begin
      szs3 = SZS_W'(szp2_ff[0]) + SZS_W'(szp2_ff[1]) + SZS_W'(szp2_ff[2]);
      inner3 = IW'(signed'({1'b0, szs3})) - IW'(signed'({1'b0, q2_ff}))
               - IW'(signed'({1'b0, nab2_ff}));
      h3_in = HW'(inner3) <<< 2;
      for (int i = 0; i < 3; i++) begin
         w3_in[i] = WW'(signed'({1'b0, z2_ff[i], 1'b0})) - WW'(signed'({1'b0, ns2_ff[i]}));
      end
      dsq3_in = DSQ_W'(dsp2_ff[0]) + DSQ_W'(dsp2_ff[1]) + DSQ_W'(dsp2_ff[2]);
   end

   // Stage 4: cross products and order-weighted distance.
   always_comb begin
      cp4_in[0] = CPW'(d3_ff[1]) * CPW'(w3_ff[2]);
      cp4_in[1] = CPW'(d3_ff[2]) * CPW'(w3_ff[1]);
      cp4_in[2] = CPW'(d3_ff[2]) * CPW'(w3_ff[0]);
      cp4_in[3] = CPW'(d3_ff[0]) * CPW'(w3_ff[2]);
      cp4_in[4] = CPW'(d3_ff[0]) * CPW'(w3_ff[1]);
      cp4_in[5] = CPW'(d3_ff[1]) * CPW'(w3_ff[0]);
      ks3 = signed'({1'b0, order_k_ff}) - KOFF3;
      ks4 = signed'({1'b0, order_k_ff}) - KOFF4;
      kd3_in = KD_W'(ks3) * KD_W'(signed'({1'b0, dsq3_ff}));
      kd4_in = KD_W'(ks4) * KD_W'(signed'({1'b0, dsq3_ff}));
   end

   // Stage 5: cross components, lane values and their magnitudes.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c5[i] = CW'(cp4_ff[2*i]) - CW'(cp4_ff[2*i+1]);
         cmag5_in[i] = c5[i][CW-1] ? (~$unsigned(c5[i]) + 1'b1) : $unsigned(c5[i]);
      end
      a3v = ((AW'(h4_ff) <<< 1) + AW'(h4_ff)) - (AW'(kd3_ff) <<< 2);
      a4v = (AW'(h4_ff) <<< 1) - ((AW'(kd4_ff) <<< 1) + AW'(kd4_ff));
      apos5_in[0] = !a3v[AW-1] && (a3v != '0);
      apos5_in[1] = !a4v[AW-1] && (a4v != '0);
      amag5_in[0] = apos5_in[0] ? a3v[AM_W-1:0] : '0;
      amag5_in[1] = apos5_in[1] ? a4v[AM_W-1:0] : '0;
   end

   // Stages 6 and 7: wide squares.
   for (genvar g = 0; g < 3; g++) begin : g_csq
      mplt_square #(.W(CW)) u_csq (
         .clock(clock),
         .operand(cmag5_ff[g]),
         .square(csq7[g])
      );
   end

   for (genvar g = 0; g < 2; g++) begin : g_asq
      mplt_square #(.W(AM_W)) u_asq (
         .clock(clock),
         .operand(amag5_ff[g]),
         .square(asq7[g])
      );
   end

   // Stage 8: sum of squared cross components and its scaled forms.
   always_comb begin
      x7 = X_W'(csq7[0]) + X_W'(csq7[1]) + X_W'(csq7[2]);
      x8_in = X12_W'(x7) << 3;
      x12_in = (X12_W'(x7) << 3) + (X12_W'(x7) << 2);
   end

   // Stage 9: lane compares.
   always_comb begin
      q3_in = valid_ff[NST-1] && m8_ff[mplt_pkg::LANE_Q3] && apos8_ff[0]
              && (CMP_W'(asq8_ff[0]) > CMP_W'(x12_ff));
      q4_in = valid_ff[NST-1] && m8_ff[mplt_pkg::LANE_Q4] && apos8_ff[1]
              && (CMP_W'(asq8_ff[1]) > CMP_W'(x8_ff));
   end

   always_ff @(posedge clock) begin
      d1_ff <= d1_in;
      s1_ff <= s1_in;
      abp1_ff <= abp1_in;
      n1_ff <= n1_in;
      z1_ff <= zin;
      q1_ff <= req_group_sq_sum;
      m1_ff <= req_lane_mask;

      nab2_ff <= nab2_in;
      szp2_ff <= szp2_in;
      ns2_ff <= ns2_in;
      dsp2_ff <= dsp2_in;
      d2_ff <= d1_ff;
      z2_ff <= z1_ff;
      q2_ff <= q1_ff;
      m2_ff <= m1_ff;

      h3_ff <= h3_in;
      w3_ff <= w3_in;
      dsq3_ff <= dsq3_in;
      d3_ff <= d2_ff;
      m3_ff <= m2_ff;

      cp4_ff <= cp4_in;
      kd3_ff <= kd3_in;
      kd4_ff <= kd4_in;
      h4_ff <= h3_ff;
      m4_ff <= m3_ff;

      cmag5_ff <= cmag5_in;
      amag5_ff <= amag5_in;
      apos5_ff <= apos5_in;
      m5_ff <= m4_ff;

      apos6_ff <= apos5_ff;
      m6_ff <= m5_ff;
      apos7_ff <= apos6_ff;
      m7_ff <= m6_ff;

      x8_ff <= x8_in;
      x12_ff <= x12_in;
      asq8_ff <= asq7;
      apos8_ff <= apos7_ff;
      m8_ff <= m7_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_lane_q3_pass = q3_ff;
   assign rsp_lane_q4_pass = q4_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("transfer did not produce a result after the pipeline latency");

   a_no_flag_when_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !rsp_lane_q3_pass && !rsp_lane_q4_pass)
      else $error("lane flag raised without a result");

   a_q3_requested: assert property (@(posedge clock) disable iff (reset)
      rsp_lane_q3_pass |-> $past(accept, LAT) && $past(req_lane_mask[mplt_pkg::LANE_Q3], LAT))
      else $error("q3 lane passed without being requested");

   a_q4_requested: assert property (@(posedge clock) disable iff (reset)
      rsp_lane_q4_pass |-> $past(accept, LAT) && $past(req_lane_mask[mplt_pkg::LANE_Q4], LAT))
      else $error("q4 lane passed without being requested");

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   localparam int COORD_BITS = 20;
   localparam int GROUP_MAX = 64;
   localparam int COORD_MAX = (1 << COORD_BITS) - 1;
   localparam int PIPE_LATENCY = 9;
   localparam int PHASE_ITEMS = 155;

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]            a_x;
      logic [COORD_BITS-1:0]            a_y;
      logic [COORD_BITS-1:0]            a_z;
      logic [COORD_BITS-1:0]            b_x;
      logic [COORD_BITS-1:0]            b_y;
      logic [COORD_BITS-1:0]            b_z;
      logic [mplt_pkg::CNT_W-1:0]       count;
      logic [mplt_pkg::SQ_W-1:0]        sq_sum;
      logic [mplt_pkg::SUM_W-1:0]       sum_x;
      logic [mplt_pkg::SUM_W-1:0]       sum_y;
      logic [mplt_pkg::SUM_W-1:0]       sum_z;
      logic [mplt_pkg::MASK_W-1:0]      mask;
   } pair_req_type;

   typedef struct packed {
      logic q3;
      logic q4;
   } lane_flags_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   pair_req_type req_drive;
   logic rsp_valid;
   logic rsp_lane_q3_pass;
   logic rsp_lane_q4_pass;
   logic csr_write_enable;
   logic [mplt_pkg::K_W-1:0] csr_write_data;

   lane_flags_type lane_expect[$];
   logic [mplt_pkg::K_W-1:0] order_model = mplt_pkg::K_RESET;
   int error_count = 0;
   bit idle_on = 1'b1;

   always #1 clock = ~clock;

   moment_pair_lane_test_unit #(
      .COORD_BITS(COORD_BITS),
      .GROUP_MAX(GROUP_MAX)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_point_a_x(req_drive.a_x),
      .req_point_a_y(req_drive.a_y),
      .req_point_a_z(req_drive.a_z),
      .req_point_b_x(req_drive.b_x),
      .req_point_b_y(req_drive.b_y),
      .req_point_b_z(req_drive.b_z),
      .req_group_count(req_drive.count),
      .req_group_sq_sum(req_drive.sq_sum),
      .req_group_sum_x(req_drive.sum_x),
      .req_group_sum_y(req_drive.sum_y),
      .req_group_sum_z(req_drive.sum_z),
      .req_lane_mask(req_drive.mask),
      .rsp_valid(rsp_valid),
      .rsp_lane_q3_pass(rsp_lane_q3_pass),
      .rsp_lane_q4_pass(rsp_lane_q4_pass),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   function automatic lane_flags_type predict_lanes(pair_req_type r,
                                                    logic [mplt_pkg::K_W-1:0] k);
      wide_type ax, ay, az, bx, by, bz, zx, zy, zz;
      wide_type dx, dy, dz, sx, sy, sz, wx, wy, wz, cx, cy, cz;
      wide_type n, q, ab, dsq, sdotz, h, kk, a3, a4, x;
      lane_flags_type f;
      ax = r.a_x;
      ay = r.a_y;
      az = r.a_z;
      bx = r.b_x;
      by = r.b_y;
      bz = r.b_z;
      zx = r.sum_x;
      zy = r.sum_y;
      zz = r.sum_z;
      q = r.sq_sum;
      n = (r.count > GROUP_MAX) ? GROUP_MAX : r.count;
      kk = k;
      dx = bx - ax;
      dy = by - ay;
      dz = bz - az;
      sx = ax + bx;
      sy = ay + by;
      sz = az + bz;
      wx = 2 * zx - n * sx;
      wy = 2 * zy - n * sy;
      wz = 2 * zz - n * sz;
      ab = ax * bx + ay * by + az * bz;
      dsq = dx * dx + dy * dy + dz * dz;
      sdotz = sx * zx + sy * zy + sz * zz;
      h = 4 * (sdotz - q - n * ab);
      cx = dy * wz - dz * wy;
      cy = dz * wx - dx * wz;
      cz = dx * wy - dy * wx;
      x = cx * cx + cy * cy + cz * cz;
      a3 = 3 * h - 4 * (kk - mplt_pkg::K_OFFSET_Q3) * dsq;
      a4 = 2 * h - 3 * (kk - mplt_pkg::K_OFFSET_Q4) * dsq;
      f.q3 = r.mask[mplt_pkg::LANE_Q3] && (a3 > 0) && (a3 * a3 > 12 * x);
      f.q4 = r.mask[mplt_pkg::LANE_Q4] && (a4 > 0) && (a4 * a4 > 8 * x);
      return f;
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_coord(longint v);
      if (v < 0) begin
         return '0;
      end
      if (v > COORD_MAX) begin
         return COORD_BITS'(COORD_MAX);
      end
      return COORD_BITS'(v);
   endfunction

   function automatic pair_req_type make_axis_group(int ax, int ay, int az, int bx, int by,
                                                    int bz, int sites, int count_field,
                                                    logic [mplt_pkg::MASK_W-1:0] mask);
      longint mx, my, mz;
      pair_req_type r;
      mx = (ax + bx) / 2;
      my = (ay + by) / 2;
      mz = (az + bz) / 2;
      r.a_x = COORD_BITS'(ax);
      r.a_y = COORD_BITS'(ay);
      r.a_z = COORD_BITS'(az);
      r.b_x = COORD_BITS'(bx);
      r.b_y = COORD_BITS'(by);
      r.b_z = COORD_BITS'(bz);
      r.count = mplt_pkg::CNT_W'(count_field);
      r.sum_x = mplt_pkg::SUM_W'(sites * mx);
      r.sum_y = mplt_pkg::SUM_W'(sites * my);
      r.sum_z = mplt_pkg::SUM_W'(sites * mz);
      r.sq_sum = mplt_pkg::SQ_W'(sites * (mx * mx + my * my + mz * mz));
      r.mask = mask;
      return r;
   endfunction

   function automatic pair_req_type make_cloud_pair(int spread_div);
      int a [3];
      int b [3];
      longint sums [3];
      longint sq;
      int span, rad, sites, mid, p;
      pair_req_type r;
      span = 1 << $urandom_range(1, 19);
      case ($urandom_range(0, 9)) inside
         0: sites = $urandom_range(1, GROUP_MAX);
         [1:4]: sites = $urandom_range(1, 24);
         default: sites = $urandom_range(1, 8);
      endcase
      rad = (spread_div > 0) ? span / spread_div : 0;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = $urandom_range(0, COORD_MAX);
         b[i] = clamp_coord(a[i] + int'($urandom_range(0, 2 * span)) - span);
         sums[i] = 0;
      end
      for (int j = 0; j < sites; j++) begin
         for (int i = 0; i < 3; i++) begin
            mid = (a[i] + b[i]) / 2;
            if (spread_div == 0) begin
               p = $urandom_range(0, COORD_MAX);
            end else begin
               p = clamp_coord(mid + int'($urandom_range(0, 2 * rad)) - rad);
            end
            sums[i] += p;
            sq += longint'(p) * p;
         end
      end
      r.a_x = COORD_BITS'(a[0]);
      r.a_y = COORD_BITS'(a[1]);
      r.a_z = COORD_BITS'(a[2]);
      r.b_x = COORD_BITS'(b[0]);
      r.b_y = COORD_BITS'(b[1]);
      r.b_z = COORD_BITS'(b[2]);
      r.count = mplt_pkg::CNT_W'(sites);
      r.sum_x = mplt_pkg::SUM_W'(sums[0]);
      r.sum_y = mplt_pkg::SUM_W'(sums[1]);
      r.sum_z = mplt_pkg::SUM_W'(sums[2]);
      r.sq_sum = mplt_pkg::SQ_W'(sq);
      r.mask = mplt_pkg::MASK_W'($urandom_range(0, 3));
      return r;
   endfunction

   function automatic pair_req_type make_noise_pair();
      pair_req_type r;
      r.a_x = COORD_BITS'($urandom);
      r.a_y = COORD_BITS'($urandom);
      r.a_z = COORD_BITS'($urandom);
      r.b_x = COORD_BITS'($urandom);
      r.b_y = COORD_BITS'($urandom);
      r.b_z = COORD_BITS'($urandom);
      r.count = mplt_pkg::CNT_W'($urandom);
      r.sq_sum = mplt_pkg::SQ_W'({$urandom, $urandom});
      r.sum_x = mplt_pkg::SUM_W'($urandom);
      r.sum_y = mplt_pkg::SUM_W'($urandom);
      r.sum_z = mplt_pkg::SUM_W'($urandom);
      r.mask = mplt_pkg::MASK_W'($urandom);
      return r;
   endfunction

   function automatic pair_req_type break_moments(pair_req_type r);
      case ($urandom_range(0, 3))
         0: r.count = mplt_pkg::CNT_W'($urandom);
         1: r.sq_sum = r.sq_sum
                       ^ mplt_pkg::SQ_W'({$urandom, $urandom} >> $urandom_range(0, 63));
         2: r.sum_x = r.sum_x + mplt_pkg::SUM_W'($urandom_range(1, 1000));
         default: r.b_z = COORD_BITS'($urandom);
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string field, logic want, logic got);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch on %s: expected %0b, actual %0b", field, want, got);
      end
   endtask

   always @(posedge clock) begin : lane_monitor
      lane_flags_type want;
      if (reset) begin
         order_model = mplt_pkg::K_RESET;
      end else begin
         if (rsp_valid) begin
            if (lane_expect.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("result without a pending transfer: q3 %0b q4 %0b",
                           rsp_lane_q3_pass, rsp_lane_q4_pass);
               end
            end else begin
               want = lane_expect.pop_front();
               if (want.q3 !== rsp_lane_q3_pass) begin
                  report_mismatch("lane_q3_pass", want.q3, rsp_lane_q3_pass);
               end
               if (want.q4 !== rsp_lane_q4_pass) begin
                  report_mismatch("lane_q4_pass", want.q4, rsp_lane_q4_pass);
               end
            end
         end
         if (start && !busy) begin
            lane_expect.push_back(predict_lanes(req_drive, order_model));
         end
         if (csr_write_enable) begin
            order_model = csr_write_data;
         end
      end
   end

   task automatic send_pair(pair_req_type item);
      if (idle_on) begin
         while ($urandom_range(0, 99) < 18) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      req_drive <= item;
      start <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   task automatic drain_pipeline();
      start <= 1'b0;
      while (lane_expect.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic load_order(logic [mplt_pkg::K_W-1:0] k);
      drain_pipeline();
      csr_write_enable <= 1'b1;
      csr_write_data <= k;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_field_extremes();
      pair_req_type r;
      r = '0;
      r.mask = 2'b11;
      send_pair(r);
      send_pair('1);
      r = '1;
      r.mask = 2'b00;
      send_pair(r);
      r = '0;
      r.a_x = '1;
      r.a_y = '1;
      r.a_z = '1;
      r.mask = 2'b11;
      send_pair(r);
      send_pair(make_axis_group(12345, 54321, 99999, 12345, 54321, 99999, 3, 3, 2'b11));
      for (int m = 0; m < 4; m++) begin
         send_pair(make_axis_group(100, 200, 300, 300, 600, 900, 3, 3,
                                   mplt_pkg::MASK_W'(m)));
      end
      send_pair(make_axis_group(100, 200, 300, 300, 600, 900, 2, 2, 2'b11));
      send_pair(make_axis_group(100, 200, 300, 300, 600, 900, 64, 64, 2'b11));
      send_pair(make_axis_group(100, 200, 300, 300, 600, 900, 64, 65, 2'b11));
      send_pair(make_axis_group(100, 200, 300, 300, 600, 900, 64, 127, 2'b11));
      send_pair(make_axis_group(0, 0, 0, COORD_MAX - 1, COORD_MAX - 1, COORD_MAX - 1,
                                3, 3, 2'b11));
      send_pair(make_axis_group(COORD_MAX, COORD_MAX, COORD_MAX, 1, 1, 1, 5, 5, 2'b11));
      send_pair(make_axis_group(100, 200, 300, 300, 600, 900, 1, 0, 2'b11));
      repeat (4) send_pair(make_noise_pair());
      repeat (2) send_pair(make_cloud_pair(4));
   endtask

   task automatic test_order_sweep();
      for (int k = 0; k < 16; k++) begin
         load_order(mplt_pkg::K_W'(k));
         send_pair(make_axis_group(1000, 2000, 4000, 1200, 2600, 3000, 2, 2, 2'b11));
         send_pair(make_axis_group(1000, 2000, 4000, 1200, 2600, 3000, 3, 3, 2'b11));
         send_pair(make_axis_group(1000, 2000, 4000, 1200, 2600, 3000, 8, 8, 2'b11));
         send_pair(make_axis_group(1000, 2000, 4000, 1200, 2600, 3000, 11, 11, 2'b11));
         repeat (2) send_pair(make_cloud_pair(3));
      end
   endtask

   task automatic test_random_traffic();
      logic [mplt_pkg::K_W-1:0] phase_order [6];
      int kind;
      phase_order[0] = 4'd4;
      phase_order[1] = 4'd10;
      phase_order[2] = 4'd7;
      phase_order[3] = mplt_pkg::K_W'($urandom_range(0, 15));
      phase_order[4] = 4'd10;
      phase_order[5] = 4'd4;
      for (int ph = 0; ph < 6; ph++) begin
         load_order(phase_order[ph]);
         idle_on = (ph != 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
               send_pair(make_cloud_pair($urandom_range(2, 8)));
            end else if (kind < 75) begin
               send_pair(make_cloud_pair(1));
            end else if (kind < 80) begin
               send_pair(make_cloud_pair(0));
            end else if (kind < 90) begin
               send_pair(break_moments(make_cloud_pair($urandom_range(1, 8))));
            end else begin
               send_pair(make_noise_pair());
            end
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_drive <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_order_sweep();
      test_random_traffic();
      drain_pipeline();
      if (error_count == 0 && lane_expect.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("status: fail");
      $finish;
   end

endmodule
